/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL of the button debouncer, used by its top-level file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/bdcl_pkg.sv */
// Types and constants shared by the button debouncer modules.
package bdcl_pkg;

    localparam int TimerW   = 17;
    localparam int CfgW     = 16;
    localparam int ElapsedW = 10;
    localparam int CountW   = 32;
    localparam int CfgAddrW = 1;

    localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

    localparam logic [CfgW-1:0] DebounceReset  = 16'd20;
    localparam logic [CfgW-1:0] LongPressReset = 16'd800;

    localparam logic [CfgAddrW-1:0] RegDebounce  = 1'd0;
    localparam logic [CfgAddrW-1:0] RegLongPress = 1'd1;

    typedef struct packed {
        logic              raw_pressed;
        logic              stable_state;
        logic [TimerW-1:0] debounce_timer;
        logic [TimerW-1:0] hold_timer;
        logic              long_fired;
        logic [CountW-1:0] click_counter;
        logic [CountW-1:0] long_counter;
    } t_state;

    typedef struct packed {
        logic              switch_level;
        logic [ElapsedW-1:0] elapsed_ms;
    } t_item;

    typedef struct packed {
        logic [CountW-1:0] long_total;
        logic [CountW-1:0] click_total;
        logic              long_pulse;
        logic              click_pulse;
        logic              stable_pressed;
    } t_result;

    typedef struct packed {
        logic [CfgW-1:0] debounce_ms;
        logic [CfgW-1:0] long_press_ms;
    } t_cfg;

endpackage

/* rtl/core/bdcl_step.sv */
// Combinational tick update: next debouncer state and the result word for one tick.
module bdcl_step (
    input  bdcl_pkg::t_state  i_state,
    input  bdcl_pkg::t_cfg    i_cfg,
    input  bdcl_pkg::t_item   i_item,
    output bdcl_pkg::t_state  o_state,
    output bdcl_pkg::t_result o_result
);

    function automatic logic [bdcl_pkg::TimerW-1:0] sat_add(
        input logic [bdcl_pkg::TimerW-1:0]   t,
        input logic [bdcl_pkg::ElapsedW-1:0] d
    );
        logic [bdcl_pkg::TimerW:0] s;
        s = {1'b0, t} + {{(bdcl_pkg::TimerW + 1 - bdcl_pkg::ElapsedW){1'b0}}, d};
        return s[bdcl_pkg::TimerW] ? bdcl_pkg::TimerMax : s[bdcl_pkg::TimerW-1:0];
    endfunction

    logic                          now_pressed;
    logic [bdcl_pkg::TimerW-1:0]   hold_sum;
    logic [bdcl_pkg::TimerW-1:0]   deb_sum;
    logic                          click;
    logic                          lng;
    bdcl_pkg::t_state              nxt;

    assign now_pressed = ~i_item.switch_level;
    assign hold_sum    = sat_add(i_state.hold_timer, i_item.elapsed_ms);
    assign deb_sum     = sat_add(i_state.debounce_timer, i_item.elapsed_ms);

    always_comb begin
        nxt   = i_state;
        click = 1'b0;
        lng   = 1'b0;
        if (now_pressed != i_state.raw_pressed) begin
            // A raw edge restarts debouncing; the elapsed time of this tick is dropped.
            nxt.raw_pressed    = now_pressed;
            nxt.debounce_timer = '0;
        end else if (i_state.raw_pressed == i_state.stable_state) begin
            if (i_state.stable_state) begin
                nxt.hold_timer = hold_sum;
                if (!i_state.long_fired &&
                    hold_sum >= {{(bdcl_pkg::TimerW - bdcl_pkg::CfgW){1'b0}},
                                 i_cfg.long_press_ms}) begin
                    lng              = 1'b1;
                    nxt.long_fired   = 1'b1;
                    nxt.long_counter = i_state.long_counter + 1'b1;
                end
            end
        end else begin
            nxt.debounce_timer = deb_sum;
            if (deb_sum >= {{(bdcl_pkg::TimerW - bdcl_pkg::CfgW){1'b0}}, i_cfg.debounce_ms})
            begin
                nxt.stable_state   = i_state.raw_pressed;
                nxt.debounce_timer = '0;
                nxt.hold_timer     = '0;
                nxt.long_fired     = 1'b0;
                if (!i_state.raw_pressed && !i_state.long_fired) begin
                    click             = 1'b1;
                    nxt.click_counter = i_state.click_counter + 1'b1;
                end
            end
        end
    end

    assign o_state                 = nxt;
    assign o_result.stable_pressed = nxt.stable_state;
    assign o_result.click_pulse    = click;
    assign o_result.long_pulse     = lng;
    assign o_result.click_total    = nxt.click_counter;
    assign o_result.long_total     = nxt.long_counter;

endmodule

/* rtl/core/button_debounce_click_longpress.sv */
// An accepted word is held in the input register and offered on the output from the output register.
// Throughput: one tick word per cycle; the input register, the single-pass tick update and
// the output register form a two-stage pipeline that advances whenever the output is free.
// Reset (synchronous, active low) clears both valid flags and the debouncer state and loads
// debounce_ms = 20 and long_press_ms = 800; no clearing pass follows.
`include "assert_macros.svh"

module button_debounce_click_longpress (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata fields, low bit up: switch_level[0], elapsed_ms[10:1], zero fill[15:11]
    input  logic [15:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata fields, low bit up: stable_pressed[0], click_pulse[1], long_pulse[2],
    // click_total[34:3], long_total[66:35], zero fill[71:67]
    output logic [71:0] o_m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [bdcl_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [bdcl_pkg::CfgW-1:0]     i_cfg_data
);

    logic              r_in_valid;
    bdcl_pkg::t_item   r_in_item;
    logic              r_out_valid;
    bdcl_pkg::t_result r_out;
    bdcl_pkg::t_state  r_state;
    bdcl_pkg::t_cfg    r_cfg;
    bdcl_pkg::t_state  n_state;
    bdcl_pkg::t_result n_out;
    logic              advance;

    // The stored word moves on when the output register is empty or being drained.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    bdcl_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= bdcl_pkg::DebounceReset;
            r_cfg.long_press_ms <= bdcl_pkg::LongPressReset;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                bdcl_pkg::RegDebounce:  r_cfg.debounce_ms   <= i_cfg_data;
                bdcl_pkg::RegLongPress: r_cfg.long_press_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_item.switch_level <= i_s_axis_tdata[0];
            r_in_item.elapsed_ms   <= i_s_axis_tdata[10:1];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out};

    // A click ends a press and a long press needs one held, so they never share a tick.
    `ASSERT_IMPLY(a_pulses_exclusive, i_clk, i_rst_n, r_out_valid,
        !(r_out.click_pulse && r_out.long_pulse))
    `ASSERT_IMPLY(a_click_released, i_clk, i_rst_n, r_out_valid && r_out.click_pulse,
        !r_out.stable_pressed)
    `ASSERT_IMPLY(a_long_pressed, i_clk, i_rst_n, r_out_valid && r_out.long_pulse,
        r_out.stable_pressed)
    `ASSERT_NEXT(a_click_count, i_clk, i_rst_n, advance,
        r_out.click_total == $past(r_state.click_counter) + 32'(r_out.click_pulse))
    `ASSERT_NEXT(a_stalled_word_kept, i_clk, i_rst_n, r_in_valid && !advance,
        r_in_valid && $stable(r_in_item))

endmodule

/* tb/button_debounce_click_longpress_tb.sv */
// Self-checking stream testbench for the push-button debouncer with click and long-press output.
`timescale 1ns / 1ps

module button_debounce_click_longpress_tb;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_axis_tvalid;
    logic                          o_s_axis_tready;
    // tdata fields, low bit up: switch_level[0], elapsed_ms[10:1], zero fill[15:11]
    logic [15:0]                   i_s_axis_tdata;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready;
    // tdata fields, low bit up: stable_pressed[0], click_pulse[1], long_pulse[2],
    // click_total[34:3], long_total[66:35], zero fill[71:67]
    logic [71:0]                   o_m_axis_tdata;
    logic                          i_cfg_we;
    logic [bdcl_pkg::CfgAddrW-1:0] i_cfg_addr;
    logic [bdcl_pkg::CfgW-1:0]     i_cfg_data;

    button_debounce_click_longpress dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    bdcl_pkg::t_state  btn;
    bdcl_pkg::t_cfg    cfg_now;
    bdcl_pkg::t_result status_q[$];
    int                ticks_sent = 0;
    int                mismatches = 0;
    bit                no_idle = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [bdcl_pkg::TimerW-1:0] timer_add(
        input logic [bdcl_pkg::TimerW-1:0]   t,
        input logic [bdcl_pkg::ElapsedW-1:0] d
    );
        logic [bdcl_pkg::TimerW:0] s;
        s = {1'b0, t} + {{(bdcl_pkg::TimerW + 1 - bdcl_pkg::ElapsedW){1'b0}}, d};
        return (s > {1'b0, bdcl_pkg::TimerMax}) ? bdcl_pkg::TimerMax : s[bdcl_pkg::TimerW-1:0];
    endfunction

    // Advances the button state by one tick and returns the status word it should produce.
    function automatic bdcl_pkg::t_result debounce_tick(
        input logic                          level,
        input logic [bdcl_pkg::ElapsedW-1:0] el
    );
        logic              pressed_now;
        bdcl_pkg::t_result r;
        pressed_now = ~level;
        r = '0;
        if (pressed_now != btn.raw_pressed) begin
            btn.raw_pressed = pressed_now;
            btn.debounce_timer = '0;
        end else if (btn.raw_pressed == btn.stable_state) begin
            if (btn.stable_state) begin
                btn.hold_timer = timer_add(btn.hold_timer, el);
                if (!btn.long_fired && btn.hold_timer >= {1'b0, cfg_now.long_press_ms}) begin
                    r.long_pulse = 1'b1;
                    btn.long_fired = 1'b1;
                    btn.long_counter = btn.long_counter + 1;
                end
            end
        end else begin
            btn.debounce_timer = timer_add(btn.debounce_timer, el);
            if (btn.debounce_timer >= {1'b0, cfg_now.debounce_ms}) begin
                btn.stable_state = btn.raw_pressed;
                btn.debounce_timer = '0;
                if (!btn.stable_state && !btn.long_fired) begin
                    r.click_pulse = 1'b1;
                    btn.click_counter = btn.click_counter + 1;
                end
                btn.hold_timer = '0;
                btn.long_fired = 1'b0;
            end
        end
        r.stable_pressed = btn.stable_state;
        r.click_total = btn.click_counter;
        r.long_total = btn.long_counter;
        return r;
    endfunction

    task automatic send_tick(input logic level, input logic [bdcl_pkg::ElapsedW-1:0] el);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {5'b0, el, level};
        do @(posedge i_clk); while (!o_s_axis_tready);
        status_q.push_back(debounce_tick(level, el));
        ticks_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [bdcl_pkg::CfgAddrW-1:0] idx,
                                  input logic [bdcl_pkg::CfgW-1:0]     val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bdcl_pkg::RegDebounce) begin
            cfg_now.debounce_ms = val;
        end else if (idx == bdcl_pkg::RegLongPress) begin
            cfg_now.long_press_ms = val;
        end
    endtask

    // Receiver: stalls for a random time before taking each status word, but never while no_idle is set.
    initial begin
        int stall;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_m_axis_tvalid));
        end
    end

    always @(posedge i_clk) begin : check_status
        bdcl_pkg::t_result got;
        bdcl_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[66:0];
            if (status_q.size() == 0) begin
                $error("status word with none expected: %h", got);
                mismatches++;
            end else begin
                want = status_q.pop_front();
                if (got.stable_pressed != want.stable_pressed) begin
                    $error("stable_pressed: expected %0d, got %0d",
                           want.stable_pressed, got.stable_pressed);
                    mismatches++;
                end
                if (got.click_pulse != want.click_pulse) begin
                    $error("click_pulse: expected %0d, got %0d",
                           want.click_pulse, got.click_pulse);
                    mismatches++;
                end
                if (got.long_pulse != want.long_pulse) begin
                    $error("long_pulse: expected %0d, got %0d",
                           want.long_pulse, got.long_pulse);
                    mismatches++;
                end
                if (got.click_total != want.click_total) begin
                    $error("click_total: expected %0d, got %0d",
                           want.click_total, got.click_total);
                    mismatches++;
                end
                if (got.long_total != want.long_total) begin
                    $error("long_total: expected %0d, got %0d",
                           want.long_total, got.long_total);
                    mismatches++;
                end
            end
        end
    end

    // Reset settings: bounce, a short click, a glitch, and a long press at exactly 800 ms.
    task automatic test_default_timing();
        send_tick(1'b1, 10'd0);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b0, 10'd7);
        send_tick(1'b0, 10'd10);
        send_tick(1'b1, 10'd5);
        send_tick(1'b0, 10'd3);
        send_tick(1'b0, 10'd19);
        send_tick(1'b0, 10'd1);
        send_tick(1'b0, 10'd0);
        send_tick(1'b0, 10'd500);
        send_tick(1'b1, 10'd9);
        send_tick(1'b1, 10'd25);
        send_tick(1'b0, 10'd5);
        send_tick(1'b1, 10'd5);
        send_tick(1'b0, 10'd0);
        send_tick(1'b0, 10'd20);
        send_tick(1'b0, 10'd799);
        send_tick(1'b0, 10'd1);
        send_tick(1'b0, 10'd1023);
        send_tick(1'b1, 10'd0);
        send_tick(1'b1, 10'd20);
    endtask

    // Zero debounce accepts on the first unchanged tick; zero long-press fires one tick later.
    task automatic test_zero_times();
        write_register(bdcl_pkg::RegDebounce, 16'd0);
        write_register(bdcl_pkg::RegLongPress, 16'd0);
        send_tick(1'b0, 10'd0);
        send_tick(1'b0, 10'd0);
        send_tick(1'b0, 10'd0);
        send_tick(1'b0, 10'd0);
        send_tick(1'b1, 10'd0);
        send_tick(1'b1, 10'd0);
        write_register(bdcl_pkg::RegLongPress, 16'hFFFF);
        send_tick(1'b0, 10'd0);
        send_tick(1'b0, 10'd0);
        send_tick(1'b0, 10'd0);
        send_tick(1'b1, 10'd0);
        send_tick(1'b1, 10'd0);
    endtask

    // Largest thresholds with the largest step: the hold timer runs into saturation.
    task automatic test_timer_saturation();
        write_register(bdcl_pkg::RegDebounce, 16'hFFFF);
        no_idle = 1'b1;
        send_tick(1'b0, 10'd0);
        repeat (70) send_tick(1'b0, 10'd1023);
        repeat (140) send_tick(1'b0, 10'd1023);
        send_tick(1'b1, 10'd0);
        repeat (70) send_tick(1'b1, 10'd1023);
        no_idle = 1'b0;
    endtask

    task automatic bounce_into(input logic level, input int steps_max);
        int n;
        n = $urandom_range(0, 3);
        repeat (n) begin
            send_tick(level, 10'($urandom_range(0, steps_max)));
            send_tick(~level, 10'($urandom_range(0, steps_max)));
        end
    endtask

    // One press and release with up to three bounces on each edge and random hold time.
    task automatic press_episode();
        int step_max;
        int hold_n;
        int rest_n;
        step_max = $urandom_range(1, 60);
        hold_n = $urandom_range(1, 40);
        rest_n = $urandom_range(1, 15);
        bounce_into(1'b0, step_max);
        repeat (hold_n) send_tick(1'b0, 10'($urandom_range(0, step_max)));
        bounce_into(1'b1, step_max);
        repeat (rest_n) send_tick(1'b1, 10'($urandom_range(0, step_max)));
    endtask

    task automatic test_random_presses();
        int phase;
        int stop_at;
        int phase_end;
        logic [bdcl_pkg::CfgW-1:0] deb;
        logic [bdcl_pkg::CfgW-1:0] lng;
        phase = 0;
        // The random phases bring the whole run to about 1800 tick words.
        stop_at = 1800;
        while (ticks_sent < stop_at) begin
            case ($urandom_range(0, 3))
                0: deb = 16'd0;
                1: deb = 16'($urandom_range(1, 60));
                2: deb = bdcl_pkg::DebounceReset;
                default: deb = 16'($urandom_range(61, 300));
            endcase
            case ($urandom_range(0, 4))
                0: lng = 16'd0;
                1: lng = bdcl_pkg::LongPressReset;
                2: lng = 16'hFFFF;
                default: lng = 16'($urandom_range(1, 2000));
            endcase
            write_register(bdcl_pkg::RegDebounce, deb);
            write_register(bdcl_pkg::RegLongPress, lng);
            no_idle = (phase % 3 == 2);
            phase_end = ticks_sent + 300;
            while (ticks_sent < phase_end) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 10))
                        send_tick(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
                end else begin
                    press_episode();
                end
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int waited;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = bdcl_pkg::RegDebounce;
        i_cfg_data = '0;
        btn = '0;
        cfg_now.debounce_ms = bdcl_pkg::DebounceReset;
        cfg_now.long_press_ms = bdcl_pkg::LongPressReset;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_timing();
        test_zero_times();
        test_timer_saturation();
        test_random_presses();

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        waited = 0;
        while (status_q.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        if (status_q.size() != 0) begin
            $error("%0d status words never arrived", status_q.size());
            mismatches++;
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
